### hw/rtl/cce_pkg.sv
package cce_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;

    localparam logic [6:0] DIV_SEC  = 7'd60;
    localparam logic [6:0] DIV_HOUR = 7'd24;
    localparam logic [1:0] PHASE_LAST = 2'd2;
    localparam logic [15:0] WEEK_RECIP = 16'd9363;
    localparam logic [31:0] RECIP_15 = 32'h8888_8889;
    localparam logic [31:0] RECIP_3  = 32'haaaa_aaab;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  load_second;
        logic [5:0]  load_minute;
        logic [4:0]  load_hour;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [7:0]  load_year;
        logic [31:0] load_epoch;
    } in_req_t;

    typedef struct packed {
        logic [5:0]  out_second;
        logic [5:0]  out_minute;
        logic [4:0]  out_hour;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [7:0]  out_year;
        logic [31:0] epoch_seconds;
        logic [2:0]  day_of_week;
    } out_req_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_YEAR, S_MONTH, S_EP0, S_EP1, S_EP2, S_EP3, S_SEND
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_TICK, OP_LOAD, OP_DIV_LOAD, OP_DIV_STEP, OP_YEAR_STEP,
        OP_MONTH_STEP, OP_EP0, OP_EP1, OP_EP2, OP_EP3, OP_SEND
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       div_last;
        logic [1:0] phase;
    } dp_cmd_t;

    typedef struct packed {
        logic year_stop;
        logic month_hit;
    } dp_stat_t;

    function automatic logic [8:0] days_before(input logic [3:0] i);
        logic [8:0] r;
        begin
            case (i)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd59;
                4'd3:    r = 9'd90;
                4'd4:    r = 9'd120;
                4'd5:    r = 9'd151;
                4'd6:    r = 9'd181;
                4'd7:    r = 9'd212;
                4'd8:    r = 9'd243;
                4'd9:    r = 9'd273;
                4'd10:   r = 9'd304;
                4'd11:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] wk_val(input logic [3:0] i);
        logic [2:0] r;
        begin
            case (i)
                4'd0:    r = 3'd6;
                4'd1:    r = 3'd2;
                4'd2:    r = 3'd2;
                4'd3:    r = 3'd5;
                4'd4:    r = 3'd0;
                4'd5:    r = 3'd3;
                4'd6:    r = 3'd5;
                4'd7:    r = 3'd1;
                4'd8:    r = 3'd4;
                4'd9:    r = 3'd6;
                4'd10:   r = 3'd2;
                4'd11:   r = 3'd4;
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [5:0] mon_len(input logic [3:0] m, input logic leap);
        logic [5:0] r;
        begin
            case (m)
                4'd2:                      r = leap ? 6'd29 : 6'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   r = 6'd30;
                default:                   r = 6'd31;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/calendar_clock_with_epoch_core.sv
// tick, load and idle commands pass through states EP0, EP1, EP2, EP3 and SEND to the result
// set-from-seconds first passes through DIV, YEAR and MONTH, then through EP0..EP3 and SEND
// DIV does three reciprocal divisions, then YEAR steps one year and MONTH one month per cycle
// one request is in work at a time; the next is taken while a result still waits
// reset (rst_n low, asynchronous) sets 2000-01-01 00:00:00 and clears out_valid (out_data is not reset)
module calendar_clock_with_epoch_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cce_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cce_pkg::out_req_t out_data
);
    import cce_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    cce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_data.cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    cce_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat),
        .out_data (out_data)
    );

endmodule

### hw/rtl/cce_ctrl.sv
module cce_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output cce_pkg::dp_cmd_t dp_cmd,
    input  cce_pkg::dp_stat_t dp_stat
);
    import cce_pkg::*;

    state_t     state_reg, state_next;
    logic       cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 1'b0;
            phase_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        ov_next         = ov_reg & ~out_ready;
        in_ready        = 1'b0;
        dp_cmd.op       = OP_NONE;
        dp_cmd.div_last = cnt_reg;
        dp_cmd.phase    = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_EP0;
                    case (in_cmd)
                        CMD_TICK: dp_cmd.op = OP_TICK;
                        CMD_LOAD: dp_cmd.op = OP_LOAD;
                        CMD_SET:
                        begin
                            dp_cmd.op  = OP_DIV_LOAD;
                            state_next = S_DIV;
                            cnt_next   = 1'b0;
                            phase_next = '0;
                        end
                        default:  dp_cmd.op = OP_NONE;
                    endcase
                end
            end
            S_DIV:
            begin
                dp_cmd.op = OP_DIV_STEP;
                cnt_next  = ~cnt_reg;
                if (cnt_reg)
                begin
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == PHASE_LAST)
                        state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                dp_cmd.op = OP_YEAR_STEP;
                if (dp_stat.year_stop)
                    state_next = S_MONTH;
            end
            S_MONTH:
            begin
                dp_cmd.op = OP_MONTH_STEP;
                if (dp_stat.month_hit)
                    state_next = S_EP0;
            end
            S_EP0:
            begin
                dp_cmd.op  = OP_EP0;
                state_next = S_EP1;
            end
            S_EP1:
            begin
                dp_cmd.op  = OP_EP1;
                state_next = S_EP2;
            end
            S_EP2:
            begin
                dp_cmd.op  = OP_EP2;
                state_next = S_EP3;
            end
            S_EP3:
            begin
                dp_cmd.op  = OP_EP3;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (!ov_reg || out_ready)
                begin
                    dp_cmd.op  = OP_SEND;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/cce_dp.sv
module cce_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  cce_pkg::in_req_t  in_data,
    input  cce_pkg::dp_cmd_t  dp_cmd,
    output cce_pkg::dp_stat_t dp_stat,
    output cce_pkg::out_req_t out_data
);
    import cce_pkg::*;

    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  mon_reg, mon_next;
    logic [7:0]  year_reg, year_next;

    logic [31:0] divq_reg, divq_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dcnt_reg, dcnt_next;
    logic [3:0]  midx_reg, midx_next;
    logic [31:0] acc_reg, acc_next;
    logic [8:0]  wv_reg, wv_next;
    logic [5:0]  wq_reg, wq_next;
    logic [2:0]  wd_reg, wd_next;
    out_req_t    out_reg, out_next;

    logic [6:0]  t_sec, t_min;
    logic [5:0]  t_hour, t_day, t_len;
    logic [4:0]  t_mon;

    logic [6:0]  dv;
    logic [29:0] mul_a;
    logic [31:0] mul_b;
    logic [61:0] mul_p;
    logic [31:0] quo_c;
    logic [31:0] rem_w;

    logic [8:0]  ylen;
    logic [9:0]  mlen;

    logic [3:0]  em;
    logic [8:0]  ey;
    logic [4:0]  ed;
    logic        eleap;
    logic [1:0]  ey100;
    logic [17:0] edays;
    logic [8:0]  wv_c;
    logic [24:0] wprod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= '0;
            min_reg  <= '0;
            hour_reg <= '0;
            day_reg  <= 5'd1;
            mon_reg  <= 4'd1;
            year_reg <= '0;
        end
        else
        begin
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
            day_reg  <= day_next;
            mon_reg  <= mon_next;
            year_reg <= year_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divq_reg <= divq_next;
        quo_reg  <= quo_next;
        dcnt_reg <= dcnt_next;
        midx_reg <= midx_next;
        acc_reg  <= acc_next;
        wv_reg   <= wv_next;
        wq_reg   <= wq_next;
        wd_reg   <= wd_next;
        out_reg  <= out_next;
    end

    assign out_data = out_reg;

    always_comb
    begin
        t_sec  = {1'b0, sec_reg} + 7'd1;
        t_min  = {1'b0, min_reg} + 7'd1;
        t_hour = {1'b0, hour_reg} + 6'd1;
        t_day  = {1'b0, day_reg} + 6'd1;
        t_mon  = {1'b0, mon_reg} + 5'd1;
        t_len  = mon_len(mon_reg, year_reg[1:0] == 2'd0);

        // divide by 60 as (n / 4) / 15 and by 24 as (n / 8) / 3
        dv    = (dp_cmd.phase == PHASE_LAST) ? DIV_HOUR : DIV_SEC;
        mul_a = (dp_cmd.phase == PHASE_LAST) ? {1'b0, divq_reg[31:3]} : divq_reg[31:2];
        mul_b = (dp_cmd.phase == PHASE_LAST) ? RECIP_3 : RECIP_15;
        mul_p = {32'd0, mul_a} * {30'd0, mul_b};
        quo_c = (dp_cmd.phase == PHASE_LAST) ? {3'd0, mul_p[61:33]}
                                             : {5'd0, mul_p[61:35]};
        rem_w = divq_reg - 32'(quo_reg * {25'd0, dv});

        ylen = (year_reg[1:0] != 2'd0) ? 9'd365 : 9'd366;
        mlen = {1'b0, days_before(midx_reg)}
             + {9'd0, (year_reg[1:0] == 2'd0) && (midx_reg >= 4'd2)};
        dp_stat.year_stop = ({16'd0} + dcnt_reg) < {7'd0, ylen};
        dp_stat.month_hit = dcnt_reg >= {6'd0, mlen};

        em = mon_reg;
        ey = {1'b0, year_reg};
        if (em == 4'd0)
            em = 4'd1;
        if (em > 4'd12)
        begin
            em = em - 4'd12;
            ey = ey + 9'd1;
        end
        ed    = (day_reg == 5'd0) ? 5'd1 : day_reg;
        eleap = (ey[1:0] == 2'd0);
        ey100 = (ey >= 9'd200) ? 2'd2 : ((ey >= 9'd100) ? 2'd1 : 2'd0);
        edays = 18'd1 + {11'd0, ey[8:2]} - {16'd0, ey100}
              - {17'd0, eleap && (em < 4'd3)}
              + {9'd0, days_before(em - 4'd1)} + {13'd0, ed} - 18'd1
              + 18'({9'd0, ey} * 18'd365);

        if (mon_reg >= 4'd1 && mon_reg <= 4'd12)
            wv_c = {1'b0, year_reg} + {3'd0, year_reg[7:2]}
                 + {6'd0, wk_val(mon_reg - 4'd1)} + {4'd0, day_reg}
                 + ((mon_reg < 4'd3 && year_reg[1:0] == 2'd0) ? 9'd6 : 9'd0);
        else
            wv_c = {1'b0, year_reg} + {3'd0, year_reg[7:2]} + {4'd0, day_reg};
        wprod = {16'd0, wv_reg} * {9'd0, WEEK_RECIP};

        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        day_next  = day_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        divq_next = divq_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        midx_next = midx_reg;
        acc_next  = acc_reg;
        wv_next   = wv_reg;
        wq_next   = wq_reg;
        wd_next   = wd_reg;
        out_next  = out_reg;

        case (dp_cmd.op)
            OP_TICK:
            begin
                if (t_sec < 7'd60)
                    sec_next = t_sec[5:0];
                else
                begin
                    sec_next = 6'(t_sec - 7'd60);
                    if (t_min < 7'd60)
                        min_next = t_min[5:0];
                    else
                    begin
                        min_next = 6'(t_min - 7'd60);
                        if (t_hour < 6'd24)
                            hour_next = t_hour[4:0];
                        else
                        begin
                            hour_next = 5'(t_hour - 6'd24);
                            if (t_day <= t_len)
                                day_next = t_day[4:0];
                            else
                            begin
                                day_next = 5'd1;
                                if (t_mon <= 5'd12)
                                    mon_next = t_mon[3:0];
                                else
                                begin
                                    mon_next  = 4'd1;
                                    year_next = year_reg + 8'd1;
                                end
                            end
                        end
                    end
                end
            end
            OP_LOAD:
            begin
                sec_next  = in_data.load_second;
                min_next  = in_data.load_minute;
                hour_next = in_data.load_hour;
                day_next  = in_data.load_day;
                mon_next  = in_data.load_month;
                year_next = in_data.load_year;
            end
            OP_DIV_LOAD:
            begin
                divq_next = in_data.load_epoch;
            end
            OP_DIV_STEP:
            begin
                if (!dp_cmd.div_last)
                    quo_next = quo_c;
                else
                begin
                    divq_next = quo_reg;
                    case (dp_cmd.phase)
                        2'd0:    sec_next  = rem_w[5:0];
                        2'd1:    min_next  = rem_w[5:0];
                        default:
                        begin
                            hour_next = rem_w[4:0];
                            dcnt_next = quo_reg[15:0];
                            year_next = '0;
                        end
                    endcase
                end
            end
            OP_YEAR_STEP:
            begin
                if (dp_stat.year_stop)
                    midx_next = 4'd11;
                else
                begin
                    dcnt_next = dcnt_reg - {7'd0, ylen};
                    year_next = year_reg + 8'd1;
                end
            end
            OP_MONTH_STEP:
            begin
                if (dp_stat.month_hit)
                begin
                    mon_next = midx_reg + 4'd1;
                    day_next = 5'(dcnt_reg - {6'd0, mlen} + 16'd1);
                end
                else
                    midx_next = midx_reg - 4'd1;
            end
            OP_EP0:
            begin
                acc_next = {14'd0, edays};
                wv_next  = wv_c;
            end
            OP_EP1:
            begin
                acc_next = 32'(acc_reg * 32'd24) + {27'd0, hour_reg};
                wq_next  = wprod[21:16];
            end
            OP_EP2:
            begin
                acc_next = 32'(acc_reg * 32'd60) + {26'd0, min_reg};
                wd_next  = 3'(wv_reg - ({3'd0, wq_reg} << 3) + {3'd0, wq_reg});
            end
            OP_EP3:
            begin
                acc_next = 32'(acc_reg * 32'd60) + {26'd0, sec_reg};
            end
            OP_SEND:
            begin
                out_next.out_second    = sec_reg;
                out_next.out_minute    = min_reg;
                out_next.out_hour      = hour_reg;
                out_next.out_day       = day_reg;
                out_next.out_month     = mon_reg;
                out_next.out_year      = year_reg;
                out_next.epoch_seconds = acc_reg;
                out_next.day_of_week   = wd_reg;
            end
            default: ;
        endcase
    end

endmodule
